FILE: design/sha1md_pkg.sv
// shared types and constants of the sha-1 message digest engine
`default_nettype none

package sha1md_pkg;

   // a..e of the compression in progress
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } work_vars_type;

   localparam int unsigned HASH_WORDS  = 5;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS      = 80;

   // word slots inside a block
   localparam logic [3:0] LEN_HI_SLOT = 4'd14;
   localparam logic [3:0] LAST_SLOT   = 4'd15;
   localparam logic [6:0] LAST_ROUND  = 7'(ROUNDS - 1);

   // round group boundaries
   localparam logic [6:0] GROUP1_START = 7'd20;
   localparam logic [6:0] GROUP2_START = 7'd40;
   localparam logic [6:0] GROUP3_START = 7'd60;

   localparam logic [31:0] K0 = 32'h5A82_7999;
   localparam logic [31:0] K1 = 32'h6ED9_EBA1;
   localparam logic [31:0] K2 = 32'h8F1B_BCDC;
   localparam logic [31:0] K3 = 32'hCA62_C1D6;

   localparam logic [31:0] INIT_HASH [0:HASH_WORDS-1] = '{
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };

   // the 0x80 pad byte in the first byte lane
   localparam logic [31:0] PAD_WORD = 32'h8000_0000;

   // digest word positions
   localparam logic [2:0] LAST_DIGEST_WORD = 3'(HASH_WORDS - 1);

endpackage

`default_nettype wire

FILE: design/sha1md_round.sv
// one sha-1 compression round: round function, constant and the a..e update
`default_nettype none

module sha1md_round (
   input  wire sha1md_pkg::work_vars_type vars,
   input  wire logic [31:0]               sched_word,
   input  wire logic [6:0]                round_index,
   output sha1md_pkg::work_vars_type      vars_next
);

   logic [31:0] func;
   logic [31:0] k_const;
   logic [31:0] temp;

   // round function and constant by round group
   always_comb begin
      priority if (round_index < sha1md_pkg::GROUP1_START) begin
         func    = (vars.b & vars.c) | (~vars.b & vars.d);
         k_const = sha1md_pkg::K0;
      end else if (round_index < sha1md_pkg::GROUP2_START) begin
         func    = vars.b ^ vars.c ^ vars.d;
         k_const = sha1md_pkg::K1;
      end else if (round_index < sha1md_pkg::GROUP3_START) begin
         func    = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
         k_const = sha1md_pkg::K2;
      end else begin
         func    = vars.b ^ vars.c ^ vars.d;
         k_const = sha1md_pkg::K3;
      end
   end

   // new a from rotated a, function, e, constant and schedule word
   assign temp = {vars.a[26:0], vars.a[31:27]} + func + vars.e + k_const + sched_word;

   // shift the working variables down
   always_comb begin
      vars_next.a = temp;
      vars_next.b = vars.a;
      vars_next.c = {vars.b[1:0], vars.b[31:2]};
      vars_next.d = vars.c;
      vars_next.e = vars.d;
   end

endmodule

`default_nettype wire

FILE: design/sha1_message_digest.sv
// streaming sha-1 engine: byte packing, padding, iterative compression, digest output
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   req     | req_valid req_stall req_data_word            | in
//           | req_byte_count req_last                      |
//   rsp     | rsp_valid rsp_stall rsp_digest_word          | out
//           | rsp_word_index rsp_last_word                 |
//
// a message word is taken while the sequencer is idle; the word that fills a 16-word
// block starts 80 rounds on the shared round unit, followed by the chain add.
// on a last transaction: the pad word, the zero and length words, one or two
// compressions, then five digest transactions, one per cycle unless stalled.
// req_stall is high whenever the sequencer is not idle. reset is synchronous and
// returns the engine to the standard initial hash with an empty message.
`default_nettype none

module sha1_message_digest (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_LEN   = 3'd3;
   localparam logic [2:0] S_ROUND = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   localparam int unsigned BW = sha1md_pkg::BLOCK_WORDS;
   localparam int unsigned HW = sha1md_pkg::HASH_WORDS;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  wcnt_ff, wcnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  acc_cnt_ff, acc_cnt_in;
   logic        fin_ff, fin_in;
   logic        pad_done_ff, pad_done_in;
   logic        len_done_ff, len_done_in;
   logic [63:0] msg_len_ff, msg_len_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic [31:0] hash_ff [0:HW-1];
   logic [31:0] hash_in [0:HW-1];
   logic [31:0] buf_ff [0:BW-1];

   sha1md_pkg::work_vars_type vars_ff, vars_in, vars_next;

   logic        buf_shift;
   logic [31:0] shift_word;
   logic [31:0] sched_new;

   logic [2:0]  n_clamp;
   logic [31:0] data_masked;
   logic [63:0] merged;
   logic [2:0]  total;
   logic [31:0] pad_word;
   logic [31:0] hash_packed [0:HW-1];

   // shared round unit
   sha1md_round u_round (
      .vars        (vars_ff),
      .sched_word  (buf_ff[0]),
      .round_index (round_ff),
      .vars_next   (vars_next)
   );

   // byte packing of an incoming transaction behind the held partial word
   always_comb begin
      n_clamp     = req_byte_count[2] ? 3'd4 : req_byte_count;
      data_masked = req_data_word & ~(32'hFFFF_FFFF >> {n_clamp, 3'b000});
      merged      = {acc_ff, 32'h0000_0000} |
                    ({data_masked, 32'h0000_0000} >> {acc_cnt_ff, 3'b000});
      total       = {1'b0, acc_cnt_ff} + n_clamp;
      pad_word    = acc_ff | (sha1md_pkg::PAD_WORD >> {acc_cnt_ff, 3'b000});
   end

   // next schedule word from the block shift line
   always_comb begin
      logic [31:0] mix;
      mix       = buf_ff[13] ^ buf_ff[8] ^ buf_ff[2] ^ buf_ff[0];
      sched_new = {mix[30:0], mix[31]};
   end

   // chain words as the compression leaves them
   always_comb begin
      hash_packed[0] = hash_ff[0] + vars_ff.a;
      hash_packed[1] = hash_ff[1] + vars_ff.b;
      hash_packed[2] = hash_ff[2] + vars_ff.c;
      hash_packed[3] = hash_ff[3] + vars_ff.d;
      hash_packed[4] = hash_ff[4] + vars_ff.e;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      wcnt_in     = wcnt_ff;
      acc_in      = acc_ff;
      acc_cnt_in  = acc_cnt_ff;
      fin_in      = fin_ff;
      pad_done_in = pad_done_ff;
      len_done_in = len_done_ff;
      msg_len_in  = msg_len_ff;
      round_in    = round_ff;
      out_idx_in  = out_idx_ff;
      vars_in     = vars_ff;
      buf_shift   = 1'b0;
      shift_word  = '0;
      for (int i = 0; i < HW; i++) begin
         hash_in[i] = hash_ff[i];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               msg_len_in = msg_len_ff + {58'h0, n_clamp, 3'b000};
               acc_cnt_in = total[1:0];
               fin_in     = req_last;
               if (total[2]) begin
                  buf_shift  = 1'b1;
                  shift_word = merged[63:32];
                  wcnt_in    = wcnt_ff + 4'd1;
                  acc_in     = merged[31:0];
               end else begin
                  acc_in = merged[63:32];
               end
               if (total[2] && wcnt_ff == sha1md_pkg::LAST_SLOT) begin
                  state_in = S_ROUND;
                  round_in = '0;
                  vars_in  = {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3], hash_ff[4]};
               end else if (req_last) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            buf_shift   = 1'b1;
            shift_word  = pad_word;
            acc_in      = '0;
            acc_cnt_in  = '0;
            pad_done_in = 1'b1;
            wcnt_in     = wcnt_ff + 4'd1;
            if (wcnt_ff == sha1md_pkg::LAST_SLOT) begin
               state_in = S_ROUND;
               round_in = '0;
               vars_in  = {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3], hash_ff[4]};
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            buf_shift = 1'b1;
            wcnt_in   = wcnt_ff + 4'd1;
            if (wcnt_ff == sha1md_pkg::LEN_HI_SLOT) begin
               shift_word = msg_len_ff[63:32];
               state_in   = S_LEN;
            end else if (wcnt_ff == sha1md_pkg::LAST_SLOT) begin
               state_in = S_ROUND;
               round_in = '0;
               vars_in  = {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3], hash_ff[4]};
            end
         end
         S_LEN: begin
            buf_shift   = 1'b1;
            shift_word  = msg_len_ff[31:0];
            wcnt_in     = wcnt_ff + 4'd1;
            len_done_in = 1'b1;
            state_in    = S_ROUND;
            round_in    = '0;
            vars_in     = {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3], hash_ff[4]};
         end
         S_ROUND: begin
            vars_in    = vars_next;
            buf_shift  = 1'b1;
            shift_word = sched_new;
            round_in   = round_ff + 7'd1;
            if (round_ff == sha1md_pkg::LAST_ROUND) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            round_in = '0;
            for (int i = 0; i < HW; i++) begin
               hash_in[i] = hash_packed[i];
            end
            // a last word that filled the block still owes its pad word
            priority if (len_done_ff) begin
               state_in   = S_OUT;
               out_idx_in = '0;
            end else if (fin_ff && pad_done_ff) begin
               state_in = S_FILL;
            end else if (fin_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (out_idx_ff == sha1md_pkg::LAST_DIGEST_WORD) begin
                  state_in    = S_IDLE;
                  out_idx_in  = '0;
                  fin_in      = 1'b0;
                  pad_done_in = 1'b0;
                  len_done_in = 1'b0;
                  msg_len_in  = '0;
                  wcnt_in     = '0;
                  acc_in      = '0;
                  acc_cnt_in  = '0;
                  for (int i = 0; i < HW; i++) begin
                     hash_in[i] = sha1md_pkg::INIT_HASH[i];
                  end
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and chain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         wcnt_ff     <= '0;
         acc_ff      <= '0;
         acc_cnt_ff  <= '0;
         fin_ff      <= 1'b0;
         pad_done_ff <= 1'b0;
         len_done_ff <= 1'b0;
         msg_len_ff  <= '0;
         round_ff    <= '0;
         out_idx_ff  <= '0;
         for (int i = 0; i < HW; i++) begin
            hash_ff[i] <= sha1md_pkg::INIT_HASH[i];
         end
      end else begin
         state_ff    <= state_in;
         wcnt_ff     <= wcnt_in;
         acc_ff      <= acc_in;
         acc_cnt_ff  <= acc_cnt_in;
         fin_ff      <= fin_in;
         pad_done_ff <= pad_done_in;
         len_done_ff <= len_done_in;
         msg_len_ff  <= msg_len_in;
         round_ff    <= round_in;
         out_idx_ff  <= out_idx_in;
         for (int i = 0; i < HW; i++) begin
            hash_ff[i] <= hash_in[i];
         end
      end
   end

   // working variables
   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   // block buffer and message schedule shift line
   always_ff @(posedge clock) begin
      if (buf_shift) begin
         for (int i = 0; i < BW - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
         buf_ff[BW-1] <= shift_word;
      end
   end

   // channel outputs
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_digest_word = hash_ff[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == sha1md_pkg::LAST_DIGEST_WORD);

endmodule

`default_nettype wire

FILE: tb/sha1_message_digest_tb.sv
// self-checking testbench for the streaming sha-1 message digest engine
module sha1_message_digest_tb;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  position;
      logic        is_last;
   } digest_entry_type;

   typedef struct packed {
      logic [31:0]  data;
      logic [2:0]   count;
      logic         fin;
      logic         known;
      logic [159:0] digest;
   } stim_row_type;

   localparam logic [159:0] EMPTY_SHA1 = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
   localparam logic [159:0] ABC_SHA1   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
   localparam logic [159:0] NO_DIGEST  = 160'h0;
   localparam int DIR_ROWS = 22;
   localparam int unsigned PHASE_ITEMS = 36;
   localparam int unsigned PHASE_GAP [4]   = '{0, 57, 0, 38};
   localparam int unsigned PHASE_STALL [4] = '{0, 0, 57, 38};
   localparam int unsigned STUCK_LIMIT = 4000;
   localparam int unsigned MAX_REPORTS = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // typed-in digest that travels with the current request
   logic         typed_known = 1'b0;
   logic [159:0] typed_digest = '0;

   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned error_count = 0;
   int unsigned stuck_cycles = 0;

   // hash predictor state
   logic [31:0] chain [0:4];
   logic [31:0] blk [0:15];
   int unsigned fill;
   logic [63:0] bit_len;

   digest_entry_type digest_queue [$];

   // directed stimulus
   stim_row_type dir_table [DIR_ROWS] = '{
      // empty message straight after reset
      '{32'h0000_0000, 3'd0, 1'b1, 1'b1, EMPTY_SHA1},
      // "abc" in one partial last word
      '{32'h6162_6300, 3'd3, 1'b1, 1'b1, ABC_SHA1},
      // partial words in the middle of a message pack as a byte stream
      '{32'hAABB_CCDD, 3'd1, 1'b0, 1'b0, NO_DIGEST},
      '{32'h1122_3344, 3'd2, 1'b0, 1'b0, NO_DIGEST},
      '{32'h5566_7788, 3'd3, 1'b0, 1'b0, NO_DIGEST},
      // oversized byte count on the last word counts as four
      '{32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, NO_DIGEST},
      // 56 bytes then an empty last word: padding spills into an extra block
      '{32'h0000_0000, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'hFFFF_FFFF, 3'd5, 1'b0, 1'b0, NO_DIGEST},
      '{32'h8000_0000, 3'd6, 1'b0, 1'b0, NO_DIGEST},
      '{32'h0000_0001, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'h0000_0000, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'h7FFF_FFFF, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'hDEAD_BEEF, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'h0123_4567, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'h89AB_CDEF, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, NO_DIGEST},
      '{32'h0000_0000, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'hA5A5_A5A5, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'h5A5A_5A5A, 3'd4, 1'b0, 1'b0, NO_DIGEST},
      '{32'h0000_0000, 3'd0, 1'b1, 1'b0, NO_DIGEST},
      // empty last word ignores its data bits
      '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, EMPTY_SHA1}
   };

   sha1_message_digest i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_byte_count  (req_byte_count),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // predictor back to an empty message with the initial hash
   task automatic sha_restart();
      for (int i = 0; i < 5; i++) chain[i] = sha1md_pkg::INIT_HASH[i];
      fill = 0;
      bit_len = '0;
   endtask

   // 80-round compression of the block buffer into the chain
   task automatic sha_compress();
      logic [31:0] sched [0:79];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) sched[i] = blk[i];
      for (int i = 16; i < 80; i++)
         sched[i] = rotate_left(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
         if (r < sha1md_pkg::GROUP1_START) begin
            f = (b & c) | (~b & d);
            k = sha1md_pkg::K0;
         end else if (r < sha1md_pkg::GROUP2_START) begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K1;
         end else if (r < sha1md_pkg::GROUP3_START) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1md_pkg::K2;
         end else begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K3;
         end
         t = rotate_left(a, 5) + f + e + k + sched[r];
         e = d;
         d = c;
         c = rotate_left(b, 30);
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
      fill = 0;
   endtask

   // append one byte to the block buffer
   task automatic sha_push(input logic [7:0] value);
      int unsigned pos;
      int unsigned sh;
      pos = fill & 63;
      sh = 24 - 8 * (pos % 4);
      if (pos % 4 == 0) blk[pos / 4] = 32'(value) << sh;
      else blk[pos / 4] |= 32'(value) << sh;
      fill = pos + 1;
      if (fill == 64) sha_compress();
   endtask

   // absorb one request; on the last one pad, finish and hand back the digest
   task automatic sha_absorb(input logic [31:0] data, input logic [2:0] count,
                             input logic fin, output logic [159:0] digest,
                             output logic done);
      int unsigned n;
      n = (count > 4) ? 4 : count;
      for (int i = 0; i < n; i++) sha_push(8'(data >> (24 - 8 * i)));
      bit_len += 64'(n * 8);
      done = fin;
      digest = '0;
      if (fin) begin
         sha_push(8'h80);
         if (fill > 56) begin
            for (int i = (fill + 3) / 4; i < 16; i++) blk[i] = '0;
            sha_compress();
         end
         for (int i = (fill + 3) / 4; i < 14; i++) blk[i] = '0;
         blk[sha1md_pkg::LEN_HI_SLOT] = bit_len[63:32];
         blk[sha1md_pkg::LAST_SLOT] = bit_len[31:0];
         sha_compress();
         digest = {chain[0], chain[1], chain[2], chain[3], chain[4]};
         sha_restart();
      end
   endtask

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   // random receiver stall
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // predict accepted requests, check accepted digest words, watchdog
   always @(posedge clock) begin
      logic [159:0] digest;
      logic done;
      digest_entry_type want;
      if (reset) begin
         sha_restart();
         stuck_cycles = 0;
      end else begin
         if (req_valid && !req_stall) begin
            sha_absorb(req_data_word, req_byte_count, req_last, digest, done);
            if (done) begin
               if (typed_known) digest = typed_digest;
               for (int w = 0; w < 5; w++)
                  digest_queue.push_back(digest_entry_type'{digest[159 - 32 * w -: 32], 3'(w),
                                           3'(w) == sha1md_pkg::LAST_DIGEST_WORD});
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               note_failure($sformatf("unexpected digest transaction: word %h index %0d last %0b",
                                      rsp_digest_word, rsp_word_index, rsp_last_word));
            end else begin
               want = digest_queue.pop_front();
               if (rsp_digest_word !== want.word || rsp_word_index !== want.position ||
                   rsp_last_word !== want.is_last)
                  note_failure($sformatf(
                     "digest mismatch: expected word %h index %0d last %0b, got %h %0d %0b",
                     want.word, want.position, want.is_last,
                     rsp_digest_word, rsp_word_index, rsp_last_word));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
         else stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // drive one request transaction, with random idle cycles ahead of it
   task automatic send_item(input logic [31:0] data, input logic [2:0] count, input logic fin,
                            input logic known, input logic [159:0] digest);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_word <= data;
      req_byte_count <= count;
      req_last <= fin;
      typed_known <= known;
      typed_digest <= digest;
      do @(posedge clock); while (req_stall);
   endtask

   // hold the sender off until every digest word has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(negedge clock);
   endtask

   // stimulus
   initial begin
      int unsigned sent;
      int unsigned body;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, no idling
      for (int i = 0; i < DIR_ROWS; i++)
         send_item(dir_table[i].data, dir_table[i].count, dir_table[i].fin,
                   dir_table[i].known, dir_table[i].digest);
      wait_drained();

      // random messages, mostly well formed, some with odd byte counts mid-message
      for (int p = 0; p < 4; p++) begin
         @(posedge clock);
         gap_pct = PHASE_GAP[p];
         stall_pct = PHASE_STALL[p];
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            body = ($urandom_range(3) == 0) ? $urandom_range(20, 12) : $urandom_range(6);
            for (int w = 0; w < body; w++)
               send_item(random_word(),
                         ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'd4,
                         1'b0, 1'b0, NO_DIGEST);
            send_item(random_word(), 3'($urandom_range(7)), 1'b1, 1'b0, NO_DIGEST);
            sent += body + 1;
         end
         wait_drained();
      end

      // let stray digest words show up
      repeat (200) @(posedge clock);
      if (digest_queue.size() != 0)
         note_failure($sformatf("%0d digest words never arrived", digest_queue.size()));
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
